// ===== sv/gti_pkg.sv =====
// Shared types and constants for the grid texture interpolator.
package gti_pkg;

  localparam int COORD_W           = 32;
  localparam int TEXEL_W           = 8;
  localparam int TEX_ADDR_W        = 16;
  localparam int POS_W             = 3;
  localparam int DEF_BLOCK_LOG2    = 3;
  localparam int DEF_TEX_ADDR_BITS = 16;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [TEX_ADDR_W-1:0] tex_addr;
    logic [TEXEL_W-1:0]    tex_data;
    logic [COORD_W-1:0]    u_top_left;
    logic [COORD_W-1:0]    u_top_right;
    logic [COORD_W-1:0]    u_bottom_left;
    logic [COORD_W-1:0]    u_bottom_right;
    logic [COORD_W-1:0]    v_top_left;
    logic [COORD_W-1:0]    v_top_right;
    logic [COORD_W-1:0]    v_bottom_left;
    logic [COORD_W-1:0]    v_bottom_right;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
    logic             last;
  } pix_tag_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_col;
    logic               last;
  } out_item_t;

endpackage

// ===== sv/gti_walker.sv =====
// Block walker: steps u and v across the pixel grid, one texel address per cycle of issue.
module gti_walker #(
  parameter int BLOCK_LOG2        = gti_pkg::DEF_BLOCK_LOG2,
  parameter int TEXTURE_ADDR_BITS = gti_pkg::DEF_TEX_ADDR_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  gti_pkg::in_item_t            corners,
  input  logic                         issue,
  output logic                         busy,
  output logic [TEXTURE_ADDR_BITS-1:0] addr,
  output gti_pkg::pix_tag_t            tag
);

  localparam int CW = gti_pkg::COORD_W;

  logic                  busy_r;
  logic [BLOCK_LOG2-1:0] x_r, y_r;
  logic [CW-1:0]         pu_r, pv_r, ul_r, vl_r;
  logic [CW-1:0]         udiff_r, vdiff_r;
  logic [CW-1:0]         uls_r, urs_r, vls_r, vrs_r;
  logic [CW-1:0]         ddu_r, ddv_r;
  logic [CW-1:0]         du, dv, ul_nxt, vl_nxt;
  logic [15:0]           full_addr;
  logic                  row_end, blk_end;

  assign du        = CW'($signed(udiff_r) >>> BLOCK_LOG2);
  assign dv        = CW'($signed(vdiff_r) >>> BLOCK_LOG2);
  assign ul_nxt    = ul_r + uls_r;
  assign vl_nxt    = vl_r + vls_r;
  assign row_end   = &x_r;
  assign blk_end   = row_end && (&y_r);
  assign full_addr = {pv_r[15:8], pu_r[15:8]};

  assign busy          = busy_r;
  assign addr          = full_addr[TEXTURE_ADDR_BITS-1:0];
  assign tag.pixel_row = gti_pkg::POS_W'(y_r);
  assign tag.pixel_col = gti_pkg::POS_W'(x_r);
  assign tag.last      = blk_end;

  always_ff @(posedge clk) begin
    ddu_r <= urs_r - uls_r;
    ddv_r <= vrs_r - vls_r;
    if (!rst_n) begin
      busy_r <= 1'b0;
      x_r    <= '0;
      y_r    <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      x_r     <= '0;
      y_r     <= '0;
      pu_r    <= corners.u_top_left;
      pv_r    <= corners.v_top_left;
      ul_r    <= corners.u_top_left;
      vl_r    <= corners.v_top_left;
      udiff_r <= corners.u_top_right - corners.u_top_left;
      vdiff_r <= corners.v_top_right - corners.v_top_left;
      uls_r   <= (corners.u_bottom_left - corners.u_top_left) >> BLOCK_LOG2;
      urs_r   <= (corners.u_bottom_right - corners.u_top_right) >> BLOCK_LOG2;
      vls_r   <= (corners.v_bottom_left - corners.v_top_left) >> BLOCK_LOG2;
      vrs_r   <= (corners.v_bottom_right - corners.v_top_right) >> BLOCK_LOG2;
    end else if (issue) begin
      x_r <= x_r + 1'b1;
      if (row_end) begin
        y_r     <= y_r + 1'b1;
        ul_r    <= ul_nxt;
        vl_r    <= vl_nxt;
        pu_r    <= ul_nxt;
        pv_r    <= vl_nxt;
        udiff_r <= udiff_r + ddu_r;
        vdiff_r <= vdiff_r + ddv_r;
        if (blk_end) begin
          busy_r <= 1'b0;
        end
      end else begin
        pu_r <= pu_r + du;
        pv_r <= pv_r + dv;
      end
    end
  end

endmodule

// ===== sv/grid_texture_interpolator_core.sv =====
// Top level: texture memory, block walker, read stage and output buffer.
//
//   channel | ports                        | moves
//   in      | in_valid in_ready in_data    | texel write or block render request
//   out     | out_valid out_ready out_data | one texel per pixel, row order
//
// Texel writes can transfer every cycle while the walker is idle.
// A render issues 2^(2*BLOCK_LOG2) reads (64 by default), one per cycle while the buffer has
// space, through the single read port of the texture memory; the next item transfers in
// the cycle of the last read. Results pass through the read stage into the output buffer.
// Reset idles the walker and empties the buffer; the texture memory is not cleared.
// A stalled output holds issue once the read stage and buffer hold two results between them.
module grid_texture_interpolator_core #(
  parameter int BLOCK_LOG2        = gti_pkg::DEF_BLOCK_LOG2,
  parameter int TEXTURE_ADDR_BITS = gti_pkg::DEF_TEX_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gti_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gti_pkg::out_item_t out_data
);

  localparam int DEPTH = 1 << TEXTURE_ADDR_BITS;

  logic [gti_pkg::TEXEL_W-1:0] tex_mem [DEPTH];
  logic [gti_pkg::TEXEL_W-1:0] rd_data_r;

  logic                         in_fire, start, wr_en, issue, busy, space, push, pop;
  logic [TEXTURE_ADDR_BITS-1:0] rd_addr;
  gti_pkg::pix_tag_t            tag, s1_tag_r;
  logic                         s1_valid_r;

  gti_pkg::out_item_t fifo_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r, count_nxt;
  logic [2:0]         occ;

  assign in_fire = in_valid && in_ready;
  assign start   = in_fire && (in_data.op == gti_pkg::OP_RENDER);
  assign wr_en   = in_fire && (in_data.op == gti_pkg::OP_WRITE);

  assign pop   = out_valid && out_ready;
  assign push  = s1_valid_r;
  assign occ   = 3'(count_r) + 3'(s1_valid_r) - 3'(pop);
  assign space = occ < 3'd2;
  assign issue = busy && space;

  assign in_ready = !busy || (issue && tag.last);

  gti_walker #(
    .BLOCK_LOG2        (BLOCK_LOG2),
    .TEXTURE_ADDR_BITS (TEXTURE_ADDR_BITS)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .corners (in_data),
    .issue   (issue),
    .busy    (busy),
    .addr    (rd_addr),
    .tag     (tag)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tex_mem[in_data.tex_addr[TEXTURE_ADDR_BITS-1:0]] <= in_data.tex_data;
    end
    if (issue) begin
      rd_data_r <= tex_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_tag_r <= tag;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  assign count_nxt = count_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{texel:     rd_data_r,
                            pixel_row: s1_tag_r.pixel_row,
                            pixel_col: s1_tag_r.pixel_col,
                            last:      s1_tag_r.last};
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  assign out_valid = count_r != 2'd0;
  assign out_data  = fifo_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && count_r == 2'd2 && !pop))
    else $error("read stage pushes into a full output buffer");

  a_block_done: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && tag.last && !start) |=> !busy)
    else $error("walker still busy after the last pixel of a block");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy && $past(!busy || (issue && tag.last)))
    else $error("render started while a block was still in progress");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the grid texture interpolator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHIFT        = gti_pkg::DEF_BLOCK_LOG2;
  localparam int SIDE         = 1 << SHIFT;
  localparam int NPIX         = SIDE * SIDE;
  localparam int TEX_DEPTH    = 1 << gti_pkg::TEX_ADDR_W;
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_ITEMS = 180;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [NPIX-1:0][gti_pkg::TEX_ADDR_W-1:0] addr_list_t;
  typedef logic [3:0][gti_pkg::COORD_W-1:0] corners_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gti_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gti_pkg::out_item_t out_data;

  gti_pkg::in_item_t           request_q[$];
  gti_pkg::out_item_t          pending_pixels[$];
  logic [gti_pkg::TEXEL_W-1:0] texture_mirror [TEX_DEPTH];
  bit                          texel_known [TEX_DEPTH];
  int                          n_queued = 0;
  int                          items_sent = 0;
  int                          pixels_seen = 0;
  int                          mismatches = 0;
  int                          hold_left = 0;
  bit                          hold_done = 1'b0;

  grid_texture_interpolator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic addr_list_t texel_addrs(gti_pkg::in_item_t it);
    logic [gti_pkg::COORD_W-1:0] ul, ur, vl, vr, uls, urs, vls, vrs, du, dv, pu, pv;
    addr_list_t a;
    ul  = it.u_top_left;
    ur  = it.u_top_right;
    vl  = it.v_top_left;
    vr  = it.v_top_right;
    uls = (it.u_bottom_left - ul) >> SHIFT;
    urs = (it.u_bottom_right - ur) >> SHIFT;
    vls = (it.v_bottom_left - vl) >> SHIFT;
    vrs = (it.v_bottom_right - vr) >> SHIFT;
    for (int r = 0; r < SIDE; r++) begin
      du = $signed(ur - ul) >>> SHIFT;
      dv = $signed(vr - vl) >>> SHIFT;
      pu = ul;
      pv = vl;
      for (int c = 0; c < SIDE; c++) begin
        a[r*SIDE + c] = {pv[15:8], pu[15:8]};
        pu = pu + du;
        pv = pv + dv;
      end
      ul = ul + uls;
      ur = ur + urs;
      vl = vl + vls;
      vr = vr + vrs;
    end
    return a;
  endfunction

  function automatic void predict_pixels(gti_pkg::in_item_t it);
    addr_list_t         a;
    gti_pkg::out_item_t px;
    if (it.op == gti_pkg::OP_WRITE) begin
      texture_mirror[it.tex_addr] = it.tex_data;
    end else begin
      a = texel_addrs(it);
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE; c++) begin
          px.texel     = texture_mirror[a[r*SIDE + c]];
          px.pixel_row = gti_pkg::POS_W'(r);
          px.pixel_col = gti_pkg::POS_W'(c);
          px.last      = (r == SIDE - 1) && (c == SIDE - 1);
          pending_pixels.push_back(px);
        end
      end
    end
  endfunction

  task automatic queue_texel(logic [gti_pkg::TEX_ADDR_W-1:0] addr,
                             logic [gti_pkg::TEXEL_W-1:0] data);
    gti_pkg::in_item_t it;
    it.op             = gti_pkg::OP_WRITE;
    it.tex_addr       = addr;
    it.tex_data       = data;
    it.u_top_left     = $urandom;
    it.u_top_right    = $urandom;
    it.u_bottom_left  = $urandom;
    it.u_bottom_right = $urandom;
    it.v_top_left     = $urandom;
    it.v_top_right    = $urandom;
    it.v_bottom_left  = $urandom;
    it.v_bottom_right = $urandom;
    texel_known[addr] = 1'b1;
    request_q.push_back(it);
    n_queued++;
  endtask

  // Fill every texel the block will read before the render goes out.
  task automatic queue_block(gti_pkg::in_item_t it);
    addr_list_t a;
    a = texel_addrs(it);
    for (int i = 0; i < NPIX; i++) begin
      if (!texel_known[a[i]]) queue_texel(a[i], 8'($urandom));
    end
    request_q.push_back(it);
    n_queued++;
  endtask

  function automatic gti_pkg::in_item_t make_block(corners_t u, corners_t v,
                                                   logic [gti_pkg::TEX_ADDR_W-1:0] addr,
                                                   logic [gti_pkg::TEXEL_W-1:0] data);
    gti_pkg::in_item_t it;
    it.op             = gti_pkg::OP_RENDER;
    it.tex_addr       = addr;
    it.tex_data       = data;
    it.u_top_left     = u[0];
    it.u_top_right    = u[1];
    it.u_bottom_left  = u[2];
    it.u_bottom_right = u[3];
    it.v_top_left     = v[0];
    it.v_top_right    = v[1];
    it.v_bottom_left  = v[2];
    it.v_bottom_right = v[3];
    return it;
  endfunction

  // Corners that stay within a few texels; crossed edges make the rows wander.
  function automatic corners_t local_corners(bit crossed, bit wrap_zone);
    corners_t k;
    bit       down;
    k[0] = $urandom;
    if (wrap_zone) begin
      if ($urandom_range(0, 1)) k[0][31:16] = 16'hFFFF;
      k[0][15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      k[0][15:8] = 8'h40 + 8'($urandom_range(0, 1));
    end
    k[1] = k[0] + $urandom_range(0, 32'h400) - 32'h200;
    down = $urandom_range(0, 1);
    k[2] = down ? k[0] - $urandom_range(1, 32'h200) : k[0] + $urandom_range(1, 32'h200);
    if (crossed) down = !down;
    k[3] = down ? k[1] - $urandom_range(1, 32'h200) : k[1] + $urandom_range(1, 32'h200);
    return k;
  endfunction

  initial begin
    int                             stop_at;
    int                             pick;
    logic [gti_pkg::TEX_ADDR_W-1:0] addr;
    corners_t                       uc, vc;

    queue_texel(16'h0000, 8'h00);
    queue_texel(16'hFFFF, 8'hFF);
    queue_texel(16'h00FF, 8'hA5);
    queue_texel(16'hFF00, 8'h5A);
    queue_block(make_block({4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 16'h0000, 8'h00));
    queue_block(make_block('0, '0, 16'hFFFF, 8'hFF));
    queue_block(make_block({32'h0000_0700, 32'hFFFF_FF00, 32'h0000_0700, 32'hFFFF_FF00},
                           '0, 16'h1234, 8'h81));
    queue_block(make_block({32'hFFFF_FF00, 32'h0000_0700, 32'hFFFF_FF00, 32'h0000_0700},
                           '0, 16'h8000, 8'h7E));
    queue_block(make_block('0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
                           16'h0F0F, 8'hF0));
    queue_block(make_block({32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0}, '0,
                           16'h00FF, 8'h01));
    queue_texel(16'hFFFF, 8'h3C);
    queue_block(make_block({4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 16'hFFFF, 8'hFF));

    stop_at = n_queued + RANDOM_ITEMS;
    while (n_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if (pick < 12) addr = 16'($urandom);
        else addr = {8'h3C + 8'($urandom_range(0, 9)), 8'h3C + 8'($urandom_range(0, 9))};
        queue_texel(addr, 8'($urandom));
      end else begin
        if (pick < 27) begin
          uc = {$urandom, $urandom, $urandom, $urandom};
          vc = {$urandom, $urandom, $urandom, $urandom};
        end else begin
          uc = local_corners(pick < 31, pick >= 80);
          vc = local_corners(pick < 31, pick >= 80);
        end
        queue_block(make_block(uc, vc, 16'($urandom), 8'($urandom)));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pixels(in_data);
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 &&
            ((items_sent >= 60 && items_sent < 120) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the output once for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && pixels_seen >= 256) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (pixels_seen >= 600 && pixels_seen < 1400) ||
                   ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    gti_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_seen <= pixels_seen + 1;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel: texel %02h row %0d col %0d last %0b",
                   out_data.texel, out_data.pixel_row, out_data.pixel_col, out_data.last);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.texel !== want.texel || out_data.pixel_row !== want.pixel_row ||
            out_data.pixel_col !== want.pixel_col || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("pixel mismatch: expected %02h %0d %0d %0b, got %02h %0d %0d %0b",
                     want.texel, want.pixel_row, want.pixel_col, want.last,
                     out_data.texel, out_data.pixel_row, out_data.pixel_col, out_data.last);
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gti_pkg.sv
sv/gti_walker.sv
sv/grid_texture_interpolator_core.sv
verif/tb.sv
